// ===== hw/rtl/tcw_pkg.sv =====
// shared types, constants and helpers for the text console cell writer
// no dependencies
`timescale 1ns / 1ps

package tcw_pkg;

    localparam int COLUMNS     = 80;
    localparam int ROWS        = 25;
    localparam int CELLS       = ROWS * COLUMNS;
    localparam int ADDR_W      = $clog2(CELLS);
    localparam int ROW_W       = 5;
    localparam int COL_W       = 7;
    localparam int CHAR_W      = 8;
    localparam int POS_W       = 11;
    localparam int CELL_W      = 16;
    localparam int ACT_W       = 2;
    localparam int IN_DATA_W   = 32;
    localparam int OUT_DATA_W  = 40;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int APB_ADDR_W  = 3;
    localparam int APB_DATA_W  = 32;

    localparam logic [ROW_W-1:0]  ROW_LAST  = ROW_W'(ROWS - 1);
    localparam logic [COL_W-1:0]  COL_LAST  = COL_W'(COLUMNS - 1);
    localparam logic [ADDR_W-1:0] CELL_LAST = ADDR_W'(CELLS - 1);
    localparam logic [ADDR_W-1:0] COPY_END  = ADDR_W'(CELLS - COLUMNS);
    localparam logic [ADDR_W-1:0] ROW_STEP  = ADDR_W'(COLUMNS);

    localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_RETURN    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
    localparam logic [CHAR_W-1:0] CH_TAB       = 8'h09;
    localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;
    localparam logic [CHAR_W-1:0] RESET_COLOR  = 8'h07;
    localparam logic [CHAR_W-1:0] TAB_STEP     = 8'd4;
    localparam logic [CHAR_W-1:0] TAB_MASK     = ~8'd3;

    localparam logic [ACT_W-1:0] ACT_PUT    = 2'd0;
    localparam logic [ACT_W-1:0] ACT_CLEAR  = 2'd1;
    localparam logic [ACT_W-1:0] ACT_SETCUR = 2'd2;
    localparam logic [ACT_W-1:0] ACT_READ   = 2'd3;

    localparam logic [APB_ADDR_W-1:0] REG_FILL_COLOR = 3'd0;

    typedef enum logic [2:0] {
        OP_CHAR,
        OP_NEWLINE,
        OP_RETURN,
        OP_BACKSPACE,
        OP_TAB,
        OP_CLEAR,
        OP_SETCUR,
        OP_READ
    } op_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_READ,
        ST_CLEAR,
        ST_SCROLL,
        ST_FILL
    } back_state_t;

    typedef struct packed {
        op_t              op;
        logic [CHAR_W-1:0] ch;
        logic [CHAR_W-1:0] color;
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  col;
    } queue_entry_t;

    typedef struct packed {
        logic init_done;
        logic busy;
    } back_status_t;

    typedef struct packed {
        logic              scrolled;
        logic [CELL_W-1:0] cell_data;
        logic [POS_W-1:0]  cursor_pos;
        logic [COL_W-1:0]  cursor_col;
        logic [ROW_W-1:0]  cursor_row;
    } result_t;

    function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] r,
                                                     input logic [COL_W-1:0] c);
        logic [ADDR_W-1:0] a;
        a = ADDR_W'(ADDR_W'(r) * ROW_STEP) + ADDR_W'(c);
        return a;
    endfunction

    function automatic logic [CELL_W-1:0] make_cell(input logic [CHAR_W-1:0] ch,
                                                     input logic [CHAR_W-1:0] attr);
        return {attr, ch};
    endfunction

endpackage

// ===== hw/rtl/tcw_front.sv =====
// front stage: accepts input beats, decodes them into operations, clamps targets
// depends on tcw_pkg
`timescale 1ns / 1ps

module tcw_front
    import tcw_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [IN_DATA_W-1:0] s_tdata,
    input  logic [ACT_W-1:0]     s_tuser,
    input  back_status_t         status,
    output logic                 q_valid,
    input  logic                 q_ready,
    output queue_entry_t         q_entry
);

    logic         front_valid_reg;
    logic         front_valid_next;
    queue_entry_t front_entry_reg;
    queue_entry_t decoded;
    logic         accept;

    logic [CHAR_W-1:0] in_char;
    logic [CHAR_W-1:0] in_color;
    logic [ROW_W-1:0]  in_row;
    logic [COL_W-1:0]  in_col;

    assign in_char  = s_tdata[7:0];
    assign in_color = s_tdata[15:8];
    assign in_row   = s_tdata[20:16];
    assign in_col   = s_tdata[27:21];

    assign s_tready = status.init_done && (!front_valid_reg || q_ready);
    assign accept   = s_tvalid && s_tready;
    assign q_valid  = front_valid_reg;
    assign q_entry  = front_entry_reg;

    always_comb
    begin
        decoded.ch    = in_char;
        decoded.color = in_color;
        decoded.row   = (in_row > ROW_LAST) ? ROW_LAST : in_row;
        decoded.col   = (in_col > COL_LAST) ? COL_LAST : in_col;
        decoded.op    = OP_CHAR;
        unique case (s_tuser)
            ACT_PUT:
            begin
                case (in_char)
                    CH_NEWLINE:   decoded.op = OP_NEWLINE;
                    CH_RETURN:    decoded.op = OP_RETURN;
                    CH_BACKSPACE: decoded.op = OP_BACKSPACE;
                    CH_TAB:       decoded.op = OP_TAB;
                    default:      decoded.op = OP_CHAR;
                endcase
            end
            ACT_CLEAR:  decoded.op = OP_CLEAR;
            ACT_SETCUR: decoded.op = OP_SETCUR;
            ACT_READ:   decoded.op = OP_READ;
            default:    decoded.op = OP_CHAR;
        endcase
    end

    always_comb
    begin
        if (accept)
            front_valid_next = 1'b1;
        else if (q_ready)
            front_valid_next = 1'b0;
        else
            front_valid_next = front_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            front_valid_reg <= 1'b0;
        else
            front_valid_reg <= front_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            front_entry_reg <= decoded;
    end

endmodule

// ===== hw/rtl/tcw_queue.sv =====
// short operation queue between the front stage and the back end
// depends on tcw_pkg
`timescale 1ns / 1ps

module tcw_queue
    import tcw_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    input  queue_entry_t in_entry,
    output logic         out_valid,
    input  logic         out_pop,
    output queue_entry_t out_entry
);

    queue_entry_t      entries_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;
    logic              push;
    logic              pop;

    assign in_ready  = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_entry = entries_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_pop && out_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entries_reg[wr_ptr_reg] <= in_entry;
    end

endmodule

// ===== hw/rtl/tcw_back.sv =====
// back end: cursor, cell store, clear and scroll sweeps, result register
// depends on tcw_pkg
`timescale 1ns / 1ps

module tcw_back
    import tcw_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [CHAR_W-1:0] fill_color,
    input  logic              q_valid,
    output logic              q_pop,
    input  queue_entry_t      q_entry,
    output back_status_t      status,
    output logic              m_tvalid,
    input  logic              m_tready,
    output result_t           result
);

    logic [CELL_W-1:0] mem [CELLS];
    logic [CELL_W-1:0] rdata_reg;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [CELL_W-1:0] mem_wdata;
    logic [ADDR_W-1:0] mem_raddr;

    back_state_t       state_reg;
    back_state_t       state_next;
    logic [ADDR_W-1:0] scan_reg;
    logic [ADDR_W-1:0] scan_next;
    logic              pend_reg;
    logic              pend_next;
    logic [ADDR_W-1:0] pend_addr_reg;
    logic [ADDR_W-1:0] pend_addr_next;
    logic [ROW_W-1:0]  cur_row_reg;
    logic [ROW_W-1:0]  cur_row_next;
    logic [COL_W-1:0]  cur_col_reg;
    logic [COL_W-1:0]  cur_col_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    result_t           out_reg;

    logic              out_free;
    logic              out_load;
    logic [CELL_W-1:0] ld_cell;
    logic              ld_scrolled;
    logic              wrap;
    logic [CHAR_W-1:0] tab_col;
    logic [CELL_W-1:0] fill_cell;

    assign out_free         = !out_valid_reg || m_tready;
    assign fill_cell        = make_cell(CH_SPACE, fill_color);
    assign tab_col          = ({1'b0, cur_col_reg} + TAB_STEP) & TAB_MASK;
    assign status.init_done = (state_reg != ST_INIT);
    assign status.busy      = (state_reg != ST_IDLE);
    assign m_tvalid         = out_valid_reg;
    assign result           = out_reg;

    always_comb
    begin
        state_next     = state_reg;
        scan_next      = scan_reg;
        pend_next      = 1'b0;
        pend_addr_next = pend_addr_reg;
        cur_row_next   = cur_row_reg;
        cur_col_next   = cur_col_reg;
        q_pop          = 1'b0;
        mem_we         = 1'b0;
        mem_waddr      = scan_reg;
        mem_wdata      = fill_cell;
        mem_raddr      = cell_addr(q_entry.row, q_entry.col);
        out_load       = 1'b0;
        ld_cell        = '0;
        ld_scrolled    = 1'b0;
        wrap           = 1'b0;
        unique case (state_reg)
            ST_INIT:
            begin
                mem_we    = 1'b1;
                mem_wdata = make_cell(CH_SPACE, RESET_COLOR);
                if (scan_reg == CELL_LAST)
                begin
                    scan_next  = '0;
                    state_next = ST_IDLE;
                end
                else
                    scan_next = scan_reg + 1'b1;
            end
            ST_IDLE:
            begin
                if (q_valid && out_free)
                begin
                    q_pop    = 1'b1;
                    out_load = 1'b1;
                    unique case (q_entry.op)
                        OP_CHAR:
                        begin
                            mem_we    = 1'b1;
                            mem_waddr = cell_addr(cur_row_reg, cur_col_reg);
                            mem_wdata = make_cell(q_entry.ch, q_entry.color);
                            if (cur_col_reg == COL_LAST)
                            begin
                                cur_col_next = '0;
                                wrap         = 1'b1;
                            end
                            else
                                cur_col_next = cur_col_reg + 1'b1;
                        end
                        OP_NEWLINE:
                        begin
                            cur_col_next = '0;
                            wrap         = 1'b1;
                        end
                        OP_RETURN:
                            cur_col_next = '0;
                        OP_BACKSPACE:
                        begin
                            if (cur_col_reg != '0)
                            begin
                                cur_col_next = cur_col_reg - 1'b1;
                                mem_we       = 1'b1;
                                mem_waddr    = cell_addr(cur_row_reg, cur_col_reg - 1'b1);
                                mem_wdata    = make_cell(CH_SPACE, q_entry.color);
                            end
                        end
                        OP_TAB:
                        begin
                            if (tab_col >= CHAR_W'(COLUMNS))
                            begin
                                cur_col_next = '0;
                                wrap         = 1'b1;
                            end
                            else
                                cur_col_next = tab_col[COL_W-1:0];
                        end
                        OP_CLEAR:
                        begin
                            out_load     = 1'b0;
                            cur_row_next = '0;
                            cur_col_next = '0;
                            scan_next    = '0;
                            state_next   = ST_CLEAR;
                        end
                        OP_SETCUR:
                        begin
                            cur_row_next = q_entry.row;
                            cur_col_next = q_entry.col;
                        end
                        OP_READ:
                        begin
                            out_load   = 1'b0;
                            state_next = ST_READ;
                        end
                        default:
                            out_load = 1'b1;
                    endcase
                    if (wrap)
                    begin
                        if (cur_row_reg == ROW_LAST)
                        begin
                            out_load     = 1'b0;
                            cur_row_next = ROW_LAST;
                            cur_col_next = '0;
                            scan_next    = '0;
                            state_next   = ST_SCROLL;
                        end
                        else
                            cur_row_next = cur_row_reg + 1'b1;
                    end
                end
            end
            ST_READ:
            begin
                out_load   = 1'b1;
                ld_cell    = rdata_reg;
                state_next = ST_IDLE;
            end
            ST_CLEAR:
            begin
                mem_we = 1'b1;
                if (scan_reg == CELL_LAST)
                begin
                    out_load   = 1'b1;
                    scan_next  = '0;
                    state_next = ST_IDLE;
                end
                else
                    scan_next = scan_reg + 1'b1;
            end
            ST_SCROLL:
            begin
                // copy row below up: read one cell ahead, write it back from the registered read data
                if (pend_reg)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = pend_addr_reg;
                    mem_wdata = rdata_reg;
                end
                if (scan_reg == COPY_END)
                    state_next = ST_FILL;
                else
                begin
                    mem_raddr      = scan_reg + ROW_STEP;
                    pend_next      = 1'b1;
                    pend_addr_next = scan_reg;
                    scan_next      = scan_reg + 1'b1;
                end
            end
            ST_FILL:
            begin
                mem_we = 1'b1;
                if (scan_reg == CELL_LAST)
                begin
                    out_load    = 1'b1;
                    ld_scrolled = 1'b1;
                    scan_next   = '0;
                    state_next  = ST_IDLE;
                end
                else
                    scan_next = scan_reg + 1'b1;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        if (out_load)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            scan_reg      <= '0;
            pend_reg      <= 1'b0;
            cur_row_reg   <= '0;
            cur_col_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            scan_reg      <= scan_next;
            pend_reg      <= pend_next;
            cur_row_reg   <= cur_row_next;
            cur_col_reg   <= cur_col_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_addr_reg <= pend_addr_next;
        if (out_load)
        begin
            out_reg.cursor_row <= cur_row_next;
            out_reg.cursor_col <= cur_col_next;
            out_reg.cursor_pos <= POS_W'(cell_addr(cur_row_next, cur_col_next));
            out_reg.cell_data  <= ld_cell;
            out_reg.scrolled   <= ld_scrolled;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        rdata_reg <= mem[mem_raddr];
    end

endmodule

// ===== hw/rtl/text_console_cell_writer_core.sv =====
// top level of the text console cell writer: register port, front, queue, back end
// depends on tcw_pkg, tcw_front, tcw_queue, tcw_back
//
// channel   dir  handshake          payload
// s_*       in   tvalid/tready      tuser action, tdata char/color/row/col
// m_*       out  tvalid/tready      tdata cursor row/col/pos, cell, scrolled
// apb       in   psel/penable       fill_color at byte address 0
//
// puts, controls, set cursor: result passes the front register, the queue and the back-end result register
// read cell: the result also passes the registered read of the cell store
// clear: a sweep that fills all 2000 cells; scroll: copies the rows up, then fills the last row of 80 cells
// after reset a clearing pass over all 2000 cells runs with s_tready low
// a finished result waits in the output register while the front and queue keep filling
`timescale 1ns / 1ps

module text_console_cell_writer_core
    import tcw_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // char_code, color, row, col, zero pad
    input  logic [ACT_W-1:0]      s_tuser,   // action
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // cursor_row, cursor_col, cursor_pos, cell_data, scrolled
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    logic [CHAR_W-1:0] fill_color_reg;
    logic [CHAR_W-1:0] fill_color_next;
    logic              reg_sel;

    back_status_t status;
    logic         fq_valid;
    logic         fq_ready;
    queue_entry_t fq_entry;
    logic         qb_valid;
    logic         qb_pop;
    queue_entry_t qb_entry;
    result_t      result;

    assign pready  = 1'b1;
    assign reg_sel = (paddr[APB_ADDR_W-1:2] == REG_FILL_COLOR[APB_ADDR_W-1:2]);
    assign prdata  = reg_sel ? APB_DATA_W'(fill_color_reg) : '0;

    always_comb
    begin
        fill_color_next = fill_color_reg;
        if (psel && penable && pwrite && pready && reg_sel)
            fill_color_next = pwdata[CHAR_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fill_color_reg <= RESET_COLOR;
        else
            fill_color_reg <= fill_color_next;
    end

    tcw_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .status   (status),
        .q_valid  (fq_valid),
        .q_ready  (fq_ready),
        .q_entry  (fq_entry)
    );

    tcw_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .in_entry  (fq_entry),
        .out_valid (qb_valid),
        .out_pop   (qb_pop),
        .out_entry (qb_entry)
    );

    tcw_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .fill_color (fill_color_reg),
        .q_valid    (qb_valid),
        .q_pop      (qb_pop),
        .q_entry    (qb_entry),
        .status     (status),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .result     (result)
    );

    assign m_tdata = result;

    // no result on the output while a sweep or a cell read is in progress
    assert property (@(posedge clk) disable iff (!rst_n)
        (status.busy && !(qb_pop)) |-> !(m_tvalid && $past(status.busy)))
        else $error("result present during back-end sweep");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (result.cursor_row <= ROW_LAST && result.cursor_col <= COL_LAST))
        else $error("cursor out of range");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (result.cursor_pos ==
                      POS_W'(cell_addr(result.cursor_row, result.cursor_col))))
        else $error("cursor position mismatch");

    assert property (@(posedge clk) disable iff (!rst_n)
        !status.init_done |-> !s_tready)
        else $error("input taken during clearing pass");

endmodule
